// ===== sv/lfu_pkg.sv =====
// lfu counter update: shared types, register indexes and the division step
// no dependencies; imported by lfu_counter_update

package lfu_pkg;

	localparam int unsigned MinuteW = 16;
	localparam int unsigned CountW  = 8;
	localparam int unsigned WordW   = MinuteW + CountW;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;

	localparam logic [MinuteW-1:0] DecayReset  = 16'd1;
	localparam logic [CountW-1:0]  FactorReset = 8'd10;
	localparam logic [CountW-1:0]  InitReset   = 8'd5;
	localparam logic [CountW-1:0]  CountMax    = 8'd255;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DECAY_MINUTES = 2'd0,
		CFG_LOG_FACTOR    = 2'd1,
		CFG_INITIAL_COUNT = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic               operation;
		logic [WordW-1:0]   access_word;
		logic [MinuteW-1:0] current_minute;
		logic [MinuteW-1:0] random_value;
	} in_word_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		logic [WordW-1:0]  new_word;
	} out_word_t;

	typedef struct packed {
		logic               take;
		logic [MinuteW-1:0] rem;
	} div_step_t;

	// one restoring division step for quotient bit sh
	function automatic div_step_t div_step(input logic [MinuteW-1:0] rem,
		input logic [MinuteW-1:0] div, input logic [2:0] sh);
		logic [WordW-1:0] dsh;
		div_step_t r;
		dsh = {{CountW{1'b0}}, div} << sh;
		r.take = {{CountW{1'b0}}, rem} >= dsh;
		r.rem = r.take ? rem - dsh[MinuteW-1:0] : rem;
		return r;
	endfunction

endpackage

// ===== sv/lfu_counter_update.sv =====
// lfu counter update: decay of the access counter, logarithmic increment, restamp
// depends on lfu_pkg

// A word given with start is taken in every cycle (busy stays low) and its
// result appears on result with result_valid high for one cycle, in order.
// Each word passes through the elapsed-minute stage, the pipelined restoring
// divider (two quotient bits per stage over four stages), then the decay
// subtract, the base-times-factor multiply and the random-value multiply,
// each in its own stage. The receiver cannot stall: results must be taken
// when shown. The user must write registers through cfg_we/cfg_index/cfg_data
// only while no word is in flight; the block itself does not enforce this.
module lfu_counter_update (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lfu_pkg::in_word_t           item,
	output logic                        result_valid,
	output lfu_pkg::out_word_t          result,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [lfu_pkg::CfgW-1:0]    cfg_data
);
	import lfu_pkg::*;

	logic [MinuteW-1:0] decay_q;
	logic [CountW-1:0]  factor_q;
	logic [CountW-1:0]  init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q  <= DecayReset;
			factor_q <= FactorReset;
			init_q   <= InitReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DECAY_MINUTES: decay_q  <= cfg_data;
				CFG_LOG_FACTOR:    factor_q <= cfg_data[CountW-1:0];
				CFG_INITIAL_COUNT: init_q   <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid bits of stages 1..7
	logic [7:1] vld;
	logic       accept;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld          <= '0;
			result_valid <= 1'b0;
		end else begin
			vld          <= {vld[6:1], accept};
			result_valid <= vld[7];
		end
	end

	// payload carried down the pipe
	in_word_t           w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7;
	logic [MinuteW-1:0] elapsed_s1;
	logic [MinuteW-1:0] rem_s2, rem_s3, rem_s4;
	logic [1:0]         q_s2;
	logic [3:0]         q_s3;
	logic [5:0]         q_s4;
	logic [7:0]         q_s5;
	logic               sat_s2, sat_s3, sat_s4, sat_s5;
	logic [CountW-1:0]  cnt_s6, cnt_s7;
	logic [CountW-1:0]  base_s6;
	logic [MinuteW-1:0] m_s7;

	// stage 1: elapsed minutes, wrap taken against 65535
	logic [MinuteW-1:0] stamp_in, elapsed_d;
	always_comb begin
		stamp_in = item.access_word[WordW-1:CountW];
		if (item.current_minute >= stamp_in)
			elapsed_d = item.current_minute - stamp_in;
		else
			elapsed_d = item.current_minute - stamp_in - MinuteW'(1);
	end

	always_ff @(posedge clk) begin
		w_s1       <= item;
		elapsed_s1 <= elapsed_d;
	end

	// stages 2..5: quotient clamped to 8 bits, sat marks elapsed >= 256 * decay
	div_step_t a2, b2, a3, b3, a4, b4, a5, b5;
	logic      sat_d;
	always_comb begin
		sat_d = {{CountW{1'b0}}, elapsed_s1[MinuteW-1:CountW]} >= decay_q;
		a2 = div_step(elapsed_s1, decay_q, 3'd7);
		b2 = div_step(a2.rem, decay_q, 3'd6);
		a3 = div_step(rem_s2, decay_q, 3'd5);
		b3 = div_step(a3.rem, decay_q, 3'd4);
		a4 = div_step(rem_s3, decay_q, 3'd3);
		b4 = div_step(a4.rem, decay_q, 3'd2);
		a5 = div_step(rem_s4, decay_q, 3'd1);
		b5 = div_step(a5.rem, decay_q, 3'd0);
	end

	always_ff @(posedge clk) begin
		w_s2   <= w_s1;
		rem_s2 <= b2.rem;
		q_s2   <= {a2.take, b2.take};
		sat_s2 <= sat_d;

		w_s3   <= w_s2;
		rem_s3 <= b3.rem;
		q_s3   <= {q_s2, a3.take, b3.take};
		sat_s3 <= sat_s2;

		w_s4   <= w_s3;
		rem_s4 <= b4.rem;
		q_s4   <= {q_s3, a4.take, b4.take};
		sat_s4 <= sat_s3;

		w_s5   <= w_s4;
		q_s5   <= {q_s4, a5.take, b5.take};
		sat_s5 <= sat_s4;
	end

	// stage 6: decayed count and increment base
	logic [CountW-1:0] cnt_in, cnt_dec;
	always_comb begin
		cnt_in = w_s5.access_word[CountW-1:0];
		if (decay_q == '0)
			cnt_dec = cnt_in;
		else if (sat_s5 || q_s5 >= cnt_in)
			cnt_dec = '0;
		else
			cnt_dec = cnt_in - q_s5;
	end

	always_ff @(posedge clk) begin
		w_s6    <= w_s5;
		cnt_s6  <= cnt_dec;
		base_s6 <= (cnt_dec > init_q) ? cnt_dec - init_q : '0;
	end

	// stage 7: base times factor
	always_ff @(posedge clk) begin
		w_s7   <= w_s6;
		cnt_s7 <= cnt_s6;
		m_s7   <= base_s6 * factor_q;
	end

	// stage 8: random draw against the scaled probability, then the result word
	logic [2*MinuteW:0]  prod;
	logic                inc;
	logic [CountW-1:0]   cnt_fin;
	out_word_t           res_d;
	always_comb begin
		prod = {{MinuteW{1'b0}}, w_s7.random_value}
			* {{MinuteW{1'b0}}, ({1'b0, m_s7} + (MinuteW+1)'(1))};
		inc = (prod[2*MinuteW:MinuteW] == '0) && (cnt_s7 != CountMax);
		cnt_fin = inc ? cnt_s7 + CountW'(1) : cnt_s7;
		if (w_s7.operation) begin
			res_d.count    = cnt_fin;
			res_d.new_word = {w_s7.current_minute, cnt_fin};
		end else begin
			res_d.count    = cnt_s7;
			res_d.new_word = w_s7.access_word;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule
